// ===== hw/rtl/buddy_pkg.sv =====
// Types, constants and helpers shared by the buddy allocator.
// Holds no logic that depends on anything else.
package buddy_pkg;

    localparam int REGION_BYTES    = 1024;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
    localparam int NSLOTS          = REGION_BYTES / MIN_BLOCK_BYTES;
    localparam int SLOT_W          = $clog2(NSLOTS);
    localparam int TOP_ORDER       = SLOT_W;
    localparam int ORDER_W         = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FIT   = 2'd1,
        STATUS_BAD_SIZE = 2'd2,
        STATUS_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPLIT,
        ST_FCHK,
        ST_MERGE,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] req_size;
        logic [9:0]  free_offset;
    } alloc_req_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  block_offset;
        logic [10:0] block_bytes;
    } alloc_rsp_t;

    typedef struct packed {
        logic               is_start;
        logic [ORDER_W-1:0] order;
        logic               free;
    } slot_t;

    // Smallest order whose block holds the request; size assumed in range.
    function automatic logic [ORDER_W-1:0] size_order(input logic [15:0] size);
        logic [ORDER_W-1:0] k;
        logic               hit;
        k   = ORDER_W'(TOP_ORDER);
        hit = 1'b0;
        for (int i = 0; i <= TOP_ORDER; i++)
        begin
            if (!hit && (17'(size) <= (17'(MIN_BLOCK_BYTES) << i)))
            begin
                k   = ORDER_W'(i);
                hit = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/buddy_allocator.sv =====
// Buddy allocator: allocate scans slots in address order one per cycle, then splits one
// level per cycle; free checks the slot, then merges one level per cycle. Depends on buddy_pkg.
// One request at a time; the next start is taken in the done cycle. done is never stalled.
// Reset leaves one free block covering the region.
module buddy_allocator
    import buddy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  alloc_req_t req,
    output logic       busy,
    output logic       done,
    output alloc_rsp_t rsp
);

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [ORDER_W-1:0] ord_reg, ord_next;
    logic [ORDER_W-1:0] k_reg, k_next;
    status_t            err_reg, err_next;
    logic               done_reg, done_next;
    alloc_rsp_t         rsp_reg, rsp_next;

    slot_t              slot_reg [NSLOTS];
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_idx;
    slot_t              wr_data;

    logic [SLOT_W-1:0]  buddy;
    logic [SLOT_W-1:0]  rd_idx;
    slot_t              rd_slot;
    logic               accept;

    assign accept  = start && !busy;
    assign buddy   = cur_reg ^ (SLOT_W'(1) << ord_reg);
    assign rd_idx  = (state_reg == ST_MERGE) ? buddy : cur_reg;
    assign rd_slot = slot_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ord_reg <= ord_next;
        k_reg   <= k_next;
        err_reg <= err_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg[0] <= '{is_start: 1'b1, order: ORDER_W'(TOP_ORDER), free: 1'b1};
            for (int i = 1; i < NSLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            slot_reg[wr_idx] <= wr_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        ord_next   = ord_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_idx     = cur_reg;
        wr_data    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.req_size == '0 ||
                            17'(req.req_size) > 17'(REGION_BYTES))
                        begin
                            err_next   = STATUS_BAD_SIZE;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            k_next     = size_order(req.req_size);
                            cur_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (req.free_offset[MIN_SHIFT-1:0] != '0)
                        begin
                            err_next   = STATUS_BAD_FREE;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            cur_next   = req.free_offset[MIN_SHIFT +: SLOT_W];
                            state_next = ST_FCHK;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_slot.is_start && rd_slot.free && rd_slot.order >= k_reg)
                begin
                    ord_next   = rd_slot.order;
                    state_next = ST_SPLIT;
                end
                else if (cur_reg == SLOT_W'(NSLOTS - 1))
                begin
                    rsp_next   = '{status: STATUS_NO_FIT, block_offset: '0, block_bytes: '0};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + SLOT_W'(1);
                end
            end

            ST_SPLIT:
            begin
                wr_en = 1'b1;
                if (ord_reg > k_reg)
                begin
                    // keep the left half, hand the right half back as free
                    ord_next = ord_reg - ORDER_W'(1);
                    wr_idx   = cur_reg | (SLOT_W'(1) << ord_next);
                    wr_data  = '{is_start: 1'b1, order: ord_next, free: 1'b1};
                end
                else
                begin
                    wr_data    = '{is_start: 1'b1, order: k_reg, free: 1'b0};
                    rsp_next   = '{status: STATUS_OK,
                                   block_offset: 10'(cur_reg) << MIN_SHIFT,
                                   block_bytes: 11'(MIN_BLOCK_BYTES) << k_reg};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FCHK:
            begin
                if (!rd_slot.is_start || rd_slot.free)
                begin
                    rsp_next   = '{status: STATUS_BAD_FREE, block_offset: '0, block_bytes: '0};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ord_next   = rd_slot.order;
                    state_next = ST_MERGE;
                end
            end

            ST_MERGE:
            begin
                wr_en = 1'b1;
                if (ord_reg < ORDER_W'(TOP_ORDER) && rd_slot.is_start && rd_slot.free &&
                    rd_slot.order == ord_reg)
                begin
                    // drop the upper start; the lower one is written on exit
                    wr_idx   = (cur_reg > buddy) ? cur_reg : buddy;
                    wr_data  = '0;
                    cur_next = (cur_reg < buddy) ? cur_reg : buddy;
                    ord_next = ord_reg + ORDER_W'(1);
                end
                else
                begin
                    wr_data    = '{is_start: 1'b1, order: ord_reg, free: 1'b1};
                    rsp_next   = '{status: STATUS_OK,
                                   block_offset: 10'(cur_reg) << MIN_SHIFT,
                                   block_bytes: 11'(MIN_BLOCK_BYTES) << ord_reg};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_ERR:
            begin
                rsp_next   = '{status: err_reg, block_offset: '0, block_bytes: '0};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while still busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STATUS_OK) |->
            (rsp.block_offset == '0 && rsp.block_bytes == '0))
        else $error("error result carries a block");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_OK) |->
            ((rsp.block_offset & 10'(rsp.block_bytes - 11'd1)) == '0))
        else $error("block offset not aligned to its size");

    a_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg[0].is_start)
        else $error("slot zero lost its block start");

endmodule

// ===== verif/buddy_allocator_tb.sv =====
// Self-checking bench for buddy_allocator: directed and random alloc/free transfers,
// each result checked against a slot-map model of the allocator kept in the bench.
// Depends on buddy_pkg and buddy_allocator.
module tb
    import buddy_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASE_ITEMS  = 450;

    typedef struct packed {
        logic               head;
        logic [ORDER_W-1:0] lvl;
        logic               avail;
    } slot_rec_t;

    typedef slot_rec_t [NSLOTS-1:0] heap_map_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    alloc_req_t req_in = '0;
    logic       busy;
    logic       done;
    alloc_rsp_t rsp_out;

    alloc_req_t req_backlog[$];
    alloc_rsp_t owed_results[$];
    heap_map_t  slot_map;
    heap_map_t  plan_map;
    int         idle_pct    = 0;
    int         fault_count = 0;
    int         cycles      = 0;

    buddy_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req_in),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic heap_map_t fresh_heap();
        heap_map_t h;
        h          = '0;
        h[0].head  = 1'b1;
        h[0].lvl   = ORDER_W'(TOP_ORDER);
        h[0].avail = 1'b1;
        return h;
    endfunction

    // Work out the outcome of one request and update the slot map to match.
    function automatic alloc_rsp_t apply_request(inout heap_map_t h, input alloc_req_t r);
        alloc_rsp_t res;
        int         need;
        int         k;
        int         found;
        int         s;
        int         o;
        int         b;
        int         lo;
        int         hi;
        int         off;
        logic       merging;
        res.status       = STATUS_OK;
        res.block_offset = '0;
        res.block_bytes  = '0;
        if (r.kind == KIND_ALLOC)
        begin
            if (r.req_size == 16'd0 || int'(r.req_size) > REGION_BYTES)
            begin
                res.status = STATUS_BAD_SIZE;
            end
            else
            begin
                need = MIN_BLOCK_BYTES;
                k    = 0;
                while (need < int'(r.req_size))
                begin
                    need = need << 1;
                    k++;
                end
                found = NSLOTS;
                for (int i = NSLOTS - 1; i >= 0; i--)
                begin
                    if (h[i].head && h[i].avail && int'(h[i].lvl) >= k)
                        found = i;
                end
                if (found == NSLOTS)
                begin
                    res.status = STATUS_NO_FIT;
                end
                else
                begin
                    // halve the block, keeping the left half, until it fits
                    while (int'(h[found].lvl) > k)
                    begin
                        o              = int'(h[found].lvl) - 1;
                        b              = found + (1 << o);
                        h[found].lvl   = ORDER_W'(o);
                        h[b].head      = 1'b1;
                        h[b].lvl       = ORDER_W'(o);
                        h[b].avail     = 1'b1;
                    end
                    h[found].avail   = 1'b0;
                    res.block_offset = 10'(found * MIN_BLOCK_BYTES);
                    res.block_bytes  = 11'(need);
                end
            end
        end
        else
        begin
            off = int'(r.free_offset);
            s   = off / MIN_BLOCK_BYTES;
            if (off % MIN_BLOCK_BYTES != 0 || off >= REGION_BYTES
                || !h[s].head || h[s].avail)
            begin
                res.status = STATUS_BAD_FREE;
            end
            else
            begin
                h[s].avail = 1'b1;
                merging    = 1'b1;
                while (merging && int'(h[s].lvl) < TOP_ORDER)
                begin
                    o = int'(h[s].lvl);
                    b = s ^ (1 << o);
                    if (!h[b].head || !h[b].avail || int'(h[b].lvl) != o)
                    begin
                        merging = 1'b0;
                    end
                    else
                    begin
                        lo         = (s < b) ? s : b;
                        hi         = (s < b) ? b : s;
                        h[hi]      = '0;
                        h[lo].head  = 1'b1;
                        h[lo].avail = 1'b1;
                        h[lo].lvl   = ORDER_W'(o + 1);
                        s          = lo;
                    end
                end
                res.block_offset = 10'(s * MIN_BLOCK_BYTES);
                res.block_bytes  = 11'(MIN_BLOCK_BYTES << h[s].lvl);
            end
        end
        return res;
    endfunction

    // Queue a request and advance the planning copy of the map so that later
    // frees can aim at blocks that will really be live.
    task automatic plan(input logic kind, input int size, input int off);
        alloc_req_t r;
        r.kind        = kind;
        r.req_size    = 16'(size);
        r.free_offset = 10'(off);
        void'(apply_request(plan_map, r));
        req_backlog.push_back(r);
    endtask

    task automatic plan_random(input int alloc_pct);
        int live[$];
        int roll;
        int size;
        int off;
        for (int s = 0; s < NSLOTS; s++)
        begin
            if (plan_map[s].head && !plan_map[s].avail)
                live.push_back(s);
        end
        size = $urandom_range(65535);
        off  = $urandom_range(1023);
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            // noise: arbitrary offset, half of them slot aligned
            if ($urandom_range(1) == 1)
                off = off & ~(MIN_BLOCK_BYTES - 1);
            plan(KIND_FREE, size, off);
        end
        else if (roll < alloc_pct || live.size() == 0)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                size = ($urandom_range(1) == 1) ? 0 : $urandom_range(65535, REGION_BYTES + 1);
            else if (roll < 60)
                size = $urandom_range(64, 1);
            else if (roll < 88)
                size = $urandom_range(256, 65);
            else
                size = $urandom_range(REGION_BYTES, 257);
            plan(KIND_ALLOC, size, off);
        end
        else
        begin
            plan(KIND_FREE, size, live[$urandom_range(live.size() - 1)] * MIN_BLOCK_BYTES);
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        fault_count++;
    endtask

    // Driver: predict on each accepted transfer, hold while busy, then launch
    // the next request unless this cycle is an idle one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start  <= 1'b0;
            req_in <= '0;
        end
        else
        begin
            if (start && !busy)
                owed_results.push_back(apply_request(slot_map, req_in));
            if (!(start && busy))
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start  <= 1'b1;
                    req_in <= req_backlog.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done cycle carries one result, checked against the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                flag_mismatch($sformatf(
                    "result with none outstanding: status %0d offset %0d bytes %0d",
                    rsp_out.status, rsp_out.block_offset, rsp_out.block_bytes));
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp_out.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", rsp_out.status, want.status));
                if (rsp_out.block_offset !== want.block_offset)
                    flag_mismatch($sformatf("block_offset %0d, want %0d",
                                            rsp_out.block_offset, want.block_offset));
                if (rsp_out.block_bytes !== want.block_bytes)
                    flag_mismatch($sformatf("block_bytes %0d, want %0d",
                                            rsp_out.block_bytes, want.block_bytes));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("buddy_allocator verification failed");
            $finish;
        end
    end

    initial
    begin
        int phase_idle[4];
        int tide;
        phase_idle = '{0, 76, 0, 21};
        slot_map   = fresh_heap();
        plan_map   = fresh_heap();

        // directed: size limits, full region, ignored fields, bad frees, merges
        plan(KIND_ALLOC, 0, 1023);
        plan(KIND_ALLOC, REGION_BYTES + 1, 0);
        plan(KIND_ALLOC, 65535, 1023);
        plan(KIND_ALLOC, REGION_BYTES, 1023);
        plan(KIND_ALLOC, 1, 0);
        plan(KIND_FREE, 65535, 0);
        plan(KIND_FREE, 0, 0);
        plan(KIND_FREE, 0, 16);
        plan(KIND_FREE, 0, 1023);
        plan(KIND_ALLOC, 1, 0);
        plan(KIND_ALLOC, 33, 0);
        plan(KIND_ALLOC, 32, 0);
        plan(KIND_FREE, 0, 96);
        plan(KIND_ALLOC, 512, 0);
        plan(KIND_ALLOC, 1000, 0);
        plan(KIND_FREE, 0, 32);
        plan(KIND_FREE, 0, 0);
        plan(KIND_FREE, 0, 64);
        plan(KIND_FREE, 0, 512);
        plan(KIND_ALLOC, 31, 1023);
        plan(KIND_FREE, 65535, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (phase_idle[p])
        begin
            while (req_backlog.size() != 0)
                @(negedge clk);
            idle_pct = phase_idle[p];
            tide     = 50;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // swing between filling and emptying the region
                if (i % 60 == 0)
                    tide = $urandom_range(75, 35);
                plan_random(tide);
            end
        end

        while (req_backlog.size() != 0 || start || owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("buddy_allocator verification clean");
        else
            $display("buddy_allocator verification failed");
        $finish;
    end

endmodule
